// ----- sv/kta_pkg.sv -----
package kta_pkg;

  localparam int CHAR_W         = 7;
  localparam int CODE_W         = 8;
  localparam int OP_W           = 2;
  localparam int HID_KEYS       = 6;
  localparam int KEY_IDX_W      = 3;
  localparam int RING_DEPTH_DEF = 128;
  localparam int PS2_ENTRIES    = 58;
  localparam int HID_ENTRIES    = 57;

  localparam logic [OP_W-1:0] OP_PS2  = 2'd0;
  localparam logic [OP_W-1:0] OP_HID  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CODE_W-1:0] code_t;

  // request from the sequencer to the character ring
  typedef struct packed {
    logic  push;
    char_t push_char;
    logic  pop;
  } ring_req_t;

  // set-1 make codes
  localparam char_t PS2_MAP [PS2_ENTRIES] = '{
    7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
    7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20
  };

  // hid keyboard usage page
  localparam char_t HID_MAP [HID_ENTRIES] = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66,
    7'h67, 7'h68, 7'h69, 7'h6a, 7'h6b, 7'h6c, 7'h6d, 7'h6e, 7'h6f, 7'h70,
    7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h0a, 7'h1b, 7'h08, 7'h09, 7'h20, 7'h2d, 7'h3d, 7'h5b, 7'h5d, 7'h5c,
    7'h23, 7'h3b, 7'h27, 7'h60, 7'h2c, 7'h2e, 7'h2f
  };

  function automatic char_t ps2_lookup(code_t code);
    char_t ch;
    ch = '0;
    if (!code[7] && (code < CODE_W'(PS2_ENTRIES))) begin
      ch = PS2_MAP[code[5:0]];
    end
    return ch;
  endfunction

  function automatic char_t hid_lookup(code_t code);
    char_t ch;
    ch = '0;
    if (code < CODE_W'(HID_ENTRIES)) begin
      ch = HID_MAP[code[5:0]];
    end
    return ch;
  endfunction

endpackage

// ----- sv/kta_xlat.sv -----
module kta_xlat (
  input  logic             hid_i,
  input  kta_pkg::code_t   code_i,
  output kta_pkg::char_t   char_o
);

  // zero means nothing to push: release, unmapped or empty slot
  assign char_o = hid_i ? kta_pkg::hid_lookup(code_i) : kta_pkg::ps2_lookup(code_i);

endmodule

// ----- sv/kta_ring.sv -----
module kta_ring #(
  parameter int RingDepth = kta_pkg::RING_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kta_pkg::ring_req_t req_i,
  output kta_pkg::char_t     rd_char_o
);

  localparam int PtrW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(RingDepth - 1);

  kta_pkg::char_t mem_q [RingDepth];
  kta_pkg::char_t rd_q;
  logic           empty_q;
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW-1:0] wptr_nxt, rptr_nxt;
  logic            empty, do_push, do_pop;

  assign wptr_nxt = (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
  assign rptr_nxt = (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
  assign empty    = (wptr_q == rptr_q);

  // a full ring drops the new character
  assign do_push = req_i.push && (req_i.push_char != '0) && (wptr_nxt != rptr_q);
  assign do_pop  = req_i.pop && !empty;

  assign wptr_d = do_push ? wptr_nxt : wptr_q;
  assign rptr_d = do_pop  ? rptr_nxt : rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      if (req_i.pop) begin
        empty_q <= empty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= req_i.push_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pop) begin
      rd_q <= mem_q[rptr_q];
    end
  end

  assign rd_char_o = empty_q ? '0 : rd_q;

endmodule

// ----- sv/keycode_to_ascii_fifo_top.sv -----
// keyboard front end: translates key codes to ascii and queues them in a ring
// input channel: operation_i selects a ps/2 scancode, a hid report of six
// usage codes, or a read of one character; the other fields are ignored
// output channel: key_char_o, one transfer per read, 0 when the ring is empty
// a ps/2 item is translated and written on its transfer
// a hid item makes one ring write per mapped usage code, in report order,
// through the single write port of the ring memory
// a read reaches the output register in steps: wait for a free output slot,
// read the ring memory, load the output
// one item is worked on at a time; a new input is taken once the last one is
// done, even while a read result still waits in the output register
// the ring holds RING_DEPTH - 1 characters; a character that finds it full
// is dropped
// a read stalled by the receiver holds the block in its read step until the
// output register frees up
// reset empties the ring (both pointers to zero) and clears the output valid
module keycode_to_ascii_fifo_top #(
  parameter int RING_DEPTH = kta_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kta_pkg::OP_W-1:0]      operation_i,
  input  logic [kta_pkg::CODE_W-1:0]    scancode_i,
  input  logic [kta_pkg::CODE_W-1:0]    key_code_0_i,
  input  logic [kta_pkg::CODE_W-1:0]    key_code_1_i,
  input  logic [kta_pkg::CODE_W-1:0]    key_code_2_i,
  input  logic [kta_pkg::CODE_W-1:0]    key_code_3_i,
  input  logic [kta_pkg::CODE_W-1:0]    key_code_4_i,
  input  logic [kta_pkg::CODE_W-1:0]    key_code_5_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kta_pkg::CHAR_W-1:0]    key_char_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HID  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  localparam logic [kta_pkg::KEY_IDX_W-1:0] LastKey =
    kta_pkg::KEY_IDX_W'(kta_pkg::HID_KEYS - 1);

  logic [1:0] state_q, state_d;
  logic [kta_pkg::KEY_IDX_W-1:0] key_idx_q, key_idx_d;
  kta_pkg::code_t codes_q [kta_pkg::HID_KEYS];
  logic out_valid_q, out_valid_d;
  kta_pkg::char_t key_char_q;
  logic in_xfer, out_free;
  logic xl_hid;
  kta_pkg::code_t xl_code;
  kta_pkg::char_t xl_char, rd_char;
  kta_pkg::ring_req_t ring_req;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign xl_hid  = (state_q == ST_HID);
  assign xl_code = xl_hid ? codes_q[key_idx_q] : scancode_i;

  kta_xlat u_xlat (
    .hid_i  (xl_hid),
    .code_i (xl_code),
    .char_o (xl_char)
  );

  always_comb begin
    state_d            = state_q;
    key_idx_d          = key_idx_q;
    out_valid_d        = out_valid_q && !out_ready_i;
    ring_req.push      = 1'b0;
    ring_req.push_char = xl_char;
    ring_req.pop       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          priority if (operation_i == kta_pkg::OP_PS2) begin
            ring_req.push = 1'b1;
          end else if (operation_i == kta_pkg::OP_HID) begin
            key_idx_d = '0;
            state_d   = ST_HID;
          end else if (operation_i == kta_pkg::OP_READ) begin
            state_d = ST_POP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_HID: begin
        ring_req.push = 1'b1;
        key_idx_d     = key_idx_q + 1'b1;
        if (key_idx_q == LastKey) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        if (out_free) begin
          ring_req.pop = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_idx_q   <= key_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      codes_q[0] <= key_code_0_i;
      codes_q[1] <= key_code_1_i;
      codes_q[2] <= key_code_2_i;
      codes_q[3] <= key_code_3_i;
      codes_q[4] <= key_code_4_i;
      codes_q[5] <= key_code_5_i;
    end
    if (state_q == ST_LOAD) begin
      key_char_q <= rd_char;
    end
  end

  kta_ring #(
    .RingDepth (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_char_o (rd_char)
  );

  assign out_valid_o = out_valid_q;
  assign key_char_o  = key_char_q;

  // the ring port never sees a write and a read in the same cycle
  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_req.push && ring_req.pop))
    else $error("ring write and read in the same cycle");

  // the output register is free when the read data lands
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !out_valid_q)
    else $error("read data would overwrite a pending result");

  // a pop is followed by the load of the output register
  a_pop_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_req.pop |=> (state_q == ST_LOAD))
    else $error("pop not followed by output load");

  // the hid walk stays within the report
  a_key_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HID) |-> (key_idx_q <= LastKey))
    else $error("hid key index out of range");

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kta_pkg::*;

  localparam int DEPTH        = 128;
  localparam int ITEM_TARGET  = 1400;
  localparam int HOLD_CYCLES  = 400;
  localparam int WATCH_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef enum int {SEG_MIXED, SEG_FILL, SEG_DRAIN} seg_e;

  typedef struct packed {
    logic [OP_W-1:0] op;
    code_t           sc;
    code_t [0:5]     keys;
    logic            chk;
    char_t           want;
  } row_t;

  // set-1 make codes 0x00..0x39
  localparam char_t MAKE_TO_ASCII [58] = '{
    7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
    7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20
  };

  // usages 0x28..0x38: enter, esc, backspace, tab, space and punctuation
  localparam char_t USAGE_PUNCT [17] = '{
    7'h0a, 7'h1b, 7'h08, 7'h09, 7'h20, 7'h2d, 7'h3d, 7'h5b, 7'h5d, 7'h5c,
    7'h23, 7'h3b, 7'h27, 7'h60, 7'h2c, 7'h2e, 7'h2f
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [OP_W-1:0]   operation_i = '0;
  code_t             scancode_i = '0;
  code_t             key_code_0_i = '0;
  code_t             key_code_1_i = '0;
  code_t             key_code_2_i = '0;
  code_t             key_code_3_i = '0;
  code_t             key_code_4_i = '0;
  code_t             key_code_5_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  char_t             key_char_o;

  keycode_to_ascii_fifo_top #(
    .RING_DEPTH(DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .scancode_i  (scancode_i),
    .key_code_0_i(key_code_0_i),
    .key_code_1_i(key_code_1_i),
    .key_code_2_i(key_code_2_i),
    .key_code_3_i(key_code_3_i),
    .key_code_4_i(key_code_4_i),
    .key_code_5_i(key_code_5_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_char_o  (key_char_o)
  );

  always #4 clk_i = ~clk_i;

  char_t buffered_chars [$];
  char_t due_chars [$];
  int    mismatches = 0;
  int    items_sent = 0;
  int    burst_left = 0;
  bit    want_hold = 1'b0;

  row_t directed_rows [25] = '{
    '{OP_READ,  8'h00, {6{8'h00}}, 1'b1, 7'h00},
    '{OP_PS2,   8'h02, {6{8'hff}}, 1'b0, 7'h00},
    '{OP_READ,  8'hff, {6{8'hff}}, 1'b1, 7'h31},
    '{OP_PS2,   8'h82, {6{8'h04}}, 1'b0, 7'h00},
    '{OP_PS2,   8'hff, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_PS2,   8'h3a, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_PS2,   8'h1d, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_READ,  8'h02, {6{8'h04}}, 1'b1, 7'h00},
    '{OP_PS2,   8'h39, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_PS2,   8'h00, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_SPARE, 8'h02, {6{8'h04}}, 1'b0, 7'h00},
    '{OP_READ,  8'h00, {6{8'h00}}, 1'b1, 7'h20},
    '{OP_HID,   8'h02, {8'h04, 8'h00, 8'hff, 8'h38, 8'h39, 8'h1d}, 1'b0, 7'h00},
    '{OP_HID,   8'h00, {6{8'hff}}, 1'b0, 7'h00},
    '{OP_HID,   8'h02, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_READ,  8'h00, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_READ,  8'h00, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_READ,  8'h00, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_READ,  8'h00, {6{8'h00}}, 1'b1, 7'h00},
    '{OP_PS2,   8'h80, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_HID,   8'h00, {8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h32}, 1'b0, 7'h00},
    '{OP_READ,  8'h00, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_READ,  8'h00, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_READ,  8'h00, {6{8'h00}}, 1'b0, 7'h00},
    '{OP_SPARE, 8'h00, {6{8'h00}}, 1'b0, 7'h00}
  };

  function automatic char_t make_char(code_t sc);
    if (sc[7] || sc > 8'd57) return '0;
    return MAKE_TO_ASCII[sc];
  endfunction

  function automatic char_t usage_char(code_t c);
    if (c >= 8'd4 && c <= 8'd29) return char_t'(8'h61 + c - 8'd4);
    if (c >= 8'd30 && c <= 8'd38) return char_t'(8'h31 + c - 8'd30);
    if (c == 8'd39) return 7'h30;
    if (c >= 8'd40 && c <= 8'd56) return USAGE_PUNCT[c - 8'd40];
    return '0;
  endfunction

  // ring keeps one slot open, so a character that meets DEPTH - 1 is lost
  function automatic void store_char(char_t ch);
    if (ch != '0 && buffered_chars.size() < DEPTH - 1) buffered_chars.push_back(ch);
  endfunction

  function automatic void translate_and_queue(row_t r);
    char_t ch;
    ch = '0;
    case (r.op)
      OP_PS2: store_char(make_char(r.sc));
      OP_HID: begin
        for (int k = 0; k < 6; k++) begin
          if (r.keys[k] != '0) store_char(usage_char(r.keys[k]));
        end
      end
      OP_READ: begin
        if (buffered_chars.size() != 0) ch = buffered_chars.pop_front();
        due_chars.push_back(r.chk ? r.want : ch);
      end
      default: ;
    endcase
  endfunction

  function automatic code_t pick_scancode();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return code_t'($urandom_range(0, 57));
    if (p < 85) return code_t'($urandom_range(0, 127)) | 8'h80;
    return code_t'($urandom_range(0, 255));
  endfunction

  function automatic code_t pick_usage(int zero_pct);
    int p;
    p = $urandom_range(0, 99);
    if (p < zero_pct) return '0;
    if (p < zero_pct + 10) return code_t'($urandom_range(0, 255));
    return code_t'($urandom_range(4, 56));
  endfunction

  function automatic row_t make_item(seg_e seg);
    row_t r;
    int   p;
    r.sc   = code_t'($urandom_range(0, 255));
    for (int k = 0; k < 6; k++) r.keys[k] = code_t'($urandom_range(0, 255));
    r.chk  = 1'b0;
    r.want = '0;
    p = $urandom_range(0, 19);
    case (seg)
      SEG_FILL: begin
        if (p < 2) begin
          r.op = OP_PS2;
          r.sc = pick_scancode();
        end else begin
          r.op = OP_HID;
          for (int k = 0; k < 6; k++) r.keys[k] = pick_usage(8);
        end
      end
      SEG_DRAIN: begin
        if (p < 16) r.op = OP_READ;
        else if (p < 19) begin
          r.op = OP_PS2;
          r.sc = pick_scancode();
        end else r.op = OP_SPARE;
      end
      default: begin
        if (p < 7) begin
          r.op = OP_PS2;
          r.sc = pick_scancode();
        end else if (p < 11) begin
          r.op = OP_HID;
          for (int k = 0; k < 6; k++) r.keys[k] = pick_usage(50);
        end else if (p < 19) r.op = OP_READ;
        else r.op = OP_SPARE;
      end
    endcase
    return r;
  endfunction

  task automatic offer(row_t r);
    int gap;
    in_valid_i   <= 1'b1;
    operation_i  <= r.op;
    scancode_i   <= r.sc;
    key_code_0_i <= r.keys[0];
    key_code_1_i <= r.keys[1];
    key_code_2_i <= r.keys[2];
    key_code_3_i <= r.keys[3];
    key_code_4_i <= r.keys[4];
    key_code_5_i <= r.keys[5];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    translate_and_queue(r);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic run_segment(seg_e seg, int n);
    for (int i = 0; i < n && items_sent < ITEM_TARGET; i++) offer(make_item(seg));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) offer(directed_rows[i]);
    while (items_sent < ITEM_TARGET) begin
      run_segment(SEG_MIXED, $urandom_range(80, 120));
      // overflow the ring, then read it dry and a bit past empty
      run_segment(SEG_FILL, $urandom_range(30, 40));
      want_hold = 1'b1;
      run_segment(SEG_DRAIN, $urandom_range(165, 185));
    end
    in_valid_i <= 1'b0;
    while (due_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: one long hold-off on request, otherwise changing stall patterns
  int  hold_left = 0;
  bit  hold_used = 1'b0;
  int  mode_left = 0;
  int  rx_mode = 0;

  always @(posedge clk_i) begin
    if (want_hold && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= $urandom_range(0, 1) == 1;
        default: out_ready_i <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  char_t got_want;

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (due_chars.size() == 0) begin
        mismatches++;
        $display("%0t: key_char expected none actual %h", $time, key_char_o);
      end else begin
        got_want = due_chars.pop_front();
        if (key_char_o !== got_want) begin
          mismatches++;
          $display("%0t: key_char expected %h actual %h", $time, got_want, key_char_o);
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCH_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- keycode_to_ascii_fifo_top.f -----
sv/kta_pkg.sv
sv/kta_xlat.sv
sv/kta_ring.sv
sv/keycode_to_ascii_fifo_top.sv
sim/tb.sv
